[hw/rtl/btpl_pkg.sv]
// Shared types and constants of the binary trie prefix lookup block.
// No dependencies; every other file imports this package.
package btpl_pkg;

  localparam int NODE_COUNT   = 1024;
  localparam int ADDRESS_BITS = 32;
  localparam int HANDLE_BITS  = 16;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int FC_W         = $clog2(NODE_COUNT + 1);
  localparam int LEN_W        = 6;
  localparam int PATH_W       = $clog2(ADDRESS_BITS);

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_BAD    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [31:0]            address;
    logic [5:0]             prefix_length;
    logic [HANDLE_BITS-1:0] route_handle;
  } in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] matched_handle;
  } out_t;

  typedef struct packed {
    logic [NODE_W-1:0]      child0;
    logic [NODE_W-1:0]      child1;
    logic                   leaf;
    logic [HANDLE_BITS-1:0] handle;
  } node_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic walk;
    logic create;
    logic del_clr;
    logic prune_rd;
    logic prune_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_lookup;
    logic is_insert;
    logic is_delete;
    logic is_bad;
    logic can_step;
    logic at_len;
    logic leaf_now;
    logic hit_now;
    logic enough;
    logic create_more;
    logic prune_go;
  } dp_stat_t;

endpackage

[hw/rtl/btpl_datapath.sv]
// Datapath of the trie lookup: node table, free node stack, walk path and walk registers.
// Depends on btpl_pkg; driven by btpl_ctrl through dp_cmd_t.
module btpl_datapath import btpl_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  in_t                    in_data_i,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  output logic [HANDLE_BITS-1:0] handle_o
);

  node_t             node_mem [NODE_COUNT];
  logic [NODE_W-1:0] free_mem [NODE_COUNT];
  logic [NODE_W-1:0] path_q   [ADDRESS_BITS];

  in_t                    in_q;
  logic [LEN_W-1:0]       len_q, lvl_q;
  logic [NODE_W-1:0]      cur_q, clr_q, frd_q;
  node_t                  cd_q, nrd_q;
  logic                   hit_q;
  logic [HANDLE_BITS-1:0] best_q;
  logic [FC_W-1:0]        fc_q, fc_d, fc_m1;

  logic              n_ren, n_wen, f_wen;
  logic [NODE_W-1:0] n_raddr, n_waddr, f_waddr, f_wdata, f_raddr, nxt, par;
  node_t             n_wdata;
  logic              bit_cur, pbit;
  logic [LEN_W-1:0]  lim, lvl_m1, lvl_m2, need;

  assign bit_cur = in_q.address[~lvl_q[PATH_W-1:0]];
  assign nxt     = bit_cur ? nrd_q.child1 : nrd_q.child0;
  assign lim     = (in_q.cmd == CMD_LOOKUP) ? LEN_W'(ADDRESS_BITS) : len_q;
  assign lvl_m1  = lvl_q - LEN_W'(1);
  assign lvl_m2  = lvl_q - LEN_W'(2);
  assign pbit    = in_q.address[~lvl_m1[PATH_W-1:0]];
  assign par     = (lvl_q == LEN_W'(1)) ? '0 : path_q[lvl_m2[PATH_W-1:0]];
  assign need    = len_q - lvl_q;
  assign fc_m1   = fc_d - FC_W'(1);
  assign f_raddr = fc_m1[NODE_W-1:0];

  always_comb begin
    n_ren   = 1'b0;
    n_raddr = '0;
    n_wen   = 1'b0;
    n_waddr = cur_q;
    n_wdata = cd_q;
    f_wen   = 1'b0;
    f_waddr = fc_q[NODE_W-1:0];
    f_wdata = cur_q;
    fc_d    = fc_q;
    if (cmd_i.clr) begin
      n_wen   = 1'b1;
      n_waddr = clr_q;
      n_wdata = '0;
      f_wen   = 1'b1;
      f_waddr = clr_q;
      f_wdata = NODE_W'(NODE_COUNT - 1) - clr_q;
    end
    if (cmd_i.load) begin
      n_ren = 1'b1;
    end
    if (cmd_i.walk && stat_o.can_step) begin
      n_ren   = 1'b1;
      n_raddr = nxt;
    end
    if (cmd_i.create) begin
      n_wen = 1'b1;
      if (stat_o.create_more) begin
        if (bit_cur) n_wdata.child1 = frd_q;
        else n_wdata.child0 = frd_q;
        fc_d = fc_q - FC_W'(1);
      end else begin
        n_wdata.leaf   = 1'b1;
        n_wdata.handle = in_q.route_handle;
      end
    end
    if (cmd_i.del_clr) begin
      n_wen          = 1'b1;
      n_wdata.leaf   = 1'b0;
      n_wdata.handle = '0;
    end
    if (cmd_i.prune_rd) begin
      n_ren   = 1'b1;
      n_raddr = par;
    end
    if (cmd_i.prune_wr) begin
      n_wen   = 1'b1;
      n_waddr = par;
      n_wdata = nrd_q;
      if (pbit) n_wdata.child1 = '0;
      else n_wdata.child0 = '0;
      f_wen = 1'b1;
      fc_d  = fc_q + FC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_wen) node_mem[n_waddr] <= n_wdata;
    if (n_ren) nrd_q <= node_mem[n_raddr];
    if (f_wen) free_mem[f_waddr] <= f_wdata;
    frd_q <= free_mem[f_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q  <= FC_W'(NODE_COUNT - 1);
      clr_q <= '0;
    end else begin
      fc_q <= fc_d;
      if (cmd_i.clr) clr_q <= clr_q + NODE_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q   <= in_data_i;
      len_q  <= (in_data_i.prefix_length > LEN_W'(ADDRESS_BITS)) ?
                LEN_W'(ADDRESS_BITS) : in_data_i.prefix_length;
      cur_q  <= '0;
      lvl_q  <= '0;
      hit_q  <= 1'b0;
      best_q <= '0;
    end
    if (cmd_i.walk) begin
      cd_q <= nrd_q;
      if (nrd_q.leaf) begin
        hit_q  <= 1'b1;
        best_q <= nrd_q.handle;
      end
      if (stat_o.can_step) begin
        cur_q <= nxt;
        lvl_q <= lvl_q + LEN_W'(1);
        path_q[lvl_q[PATH_W-1:0]] <= nxt;
      end
    end
    if (cmd_i.create && stat_o.create_more) begin
      cur_q <= frd_q;
      cd_q  <= '0;
      lvl_q <= lvl_q + LEN_W'(1);
    end
    if (cmd_i.del_clr) cd_q <= n_wdata;
    if (cmd_i.prune_wr) begin
      cd_q  <= n_wdata;
      cur_q <= par;
      lvl_q <= lvl_m1;
    end
  end

  always_comb begin
    stat_o.clr_last    = (clr_q == NODE_W'(NODE_COUNT - 1));
    stat_o.is_lookup   = (in_q.cmd == CMD_LOOKUP);
    stat_o.is_insert   = (in_q.cmd == CMD_INSERT);
    stat_o.is_delete   = (in_q.cmd == CMD_DELETE);
    stat_o.is_bad      = (in_q.cmd == CMD_BAD);
    stat_o.can_step    = (lvl_q < lim) && (nxt != '0);
    stat_o.at_len      = (lvl_q == len_q);
    stat_o.leaf_now    = nrd_q.leaf;
    stat_o.hit_now     = hit_q | nrd_q.leaf;
    stat_o.enough      = (FC_W'(need) <= fc_q);
    stat_o.create_more = (lvl_q < len_q);
    stat_o.prune_go    = !cd_q.leaf && (cd_q.child0 == '0) && (cd_q.child1 == '0) &&
                         (lvl_q != '0);
  end

  assign handle_o = (stat_o.is_lookup && hit_q) ? best_q : '0;

endmodule

[hw/rtl/btpl_ctrl.sv]
// Controller state machine of the trie lookup: sequences the clearing pass, walks, inserts and deletes.
// Depends on btpl_pkg; commands btpl_datapath.
module btpl_ctrl import btpl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_free_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o,
  output logic       res_load_o,
  output logic [1:0] status_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_INS_CHK, S_CREATE, S_DEL_CLR,
    S_PRUNE_CHK, S_PRUNE_WR, S_DONE
  } state_e;

  state_e     state_q;
  logic [1:0] status_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.clr      = (state_q == S_CLEAR);
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.walk     = (state_q == S_WALK);
    cmd_o.create   = (state_q == S_CREATE);
    cmd_o.del_clr  = (state_q == S_DEL_CLR);
    cmd_o.prune_rd = (state_q == S_PRUNE_CHK) && stat_i.prune_go;
    cmd_o.prune_wr = (state_q == S_PRUNE_WR);
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign res_load_o = (state_q == S_DONE) && out_free_i;
  assign status_o   = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      status_q <= ST_OK;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (stat_i.clr_last) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) state_q <= S_WALK;
        end
        S_WALK: begin
          if (stat_i.is_bad) begin
            status_q <= ST_MISS;
            state_q  <= S_DONE;
          end else if (!stat_i.can_step) begin
            if (stat_i.is_lookup) begin
              status_q <= stat_i.hit_now ? ST_OK : ST_MISS;
              state_q  <= S_DONE;
            end else if (stat_i.is_insert) begin
              state_q <= S_INS_CHK;
            end else if (stat_i.is_delete && stat_i.at_len && stat_i.leaf_now) begin
              state_q <= S_DEL_CLR;
            end else begin
              status_q <= ST_MISS;
              state_q  <= S_DONE;
            end
          end
        end
        S_INS_CHK: begin
          if (stat_i.enough) begin
            state_q <= S_CREATE;
          end else begin
            status_q <= ST_FULL;
            state_q  <= S_DONE;
          end
        end
        S_CREATE: begin
          if (!stat_i.create_more) begin
            status_q <= ST_OK;
            state_q  <= S_DONE;
          end
        end
        S_DEL_CLR: begin
          state_q <= S_PRUNE_CHK;
        end
        S_PRUNE_CHK: begin
          if (stat_i.prune_go) begin
            state_q <= S_PRUNE_WR;
          end else begin
            status_q <= ST_OK;
            state_q  <= S_DONE;
          end
        end
        S_PRUNE_WR: begin
          state_q <= S_PRUNE_CHK;
        end
        S_DONE: begin
          if (out_free_i) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/binary_trie_prefix_lookup.sv]
// Top level of the IPv4 longest-prefix-match binary trie.
// Depends on btpl_pkg, btpl_ctrl and btpl_datapath.

// The block keeps IPv4 routes in a 1024-entry table of binary trie nodes,
// one address bit per level, most significant bit first. Each input item is a
// lookup, an insert, a delete or the unused code, which is answered with a miss,
// and each gives exactly one result item. After reset the block clears the node
// table and fills the free node stack, and accepts no item until that pass is
// done. Items are then handled one at a time. The walk down the trie reads one
// node table entry per cycle. An insert is the walk, then a check for enough
// free nodes, then one write per new node and one for the route itself; the
// levels walked and the new nodes add up to the prefix length. A delete is the
// walk, then a write that clears the route, then, for every node that is freed
// on the way back up, a read of the parent and then a write of it. A finished
// result sits in an output register, so the next item can be accepted and
// worked on while the previous result still waits to be taken.
module binary_trie_prefix_lookup import btpl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  dp_cmd_t                dp_cmd;
  dp_stat_t               dp_stat;
  logic                   res_load, out_free;
  logic [1:0]             status;
  logic [HANDLE_BITS-1:0] handle;
  logic                   out_valid_q;
  out_t                   out_q;

  // The output register is free when empty or when its item leaves this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  btpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd),
    .res_load_o (res_load),
    .status_o   (status)
  );

  btpl_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (dp_cmd),
    .stat_o    (dp_stat),
    .handle_o  (handle)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q.status         <= status;
      out_q.matched_handle <= handle;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // A result is never produced while the block is waiting for an item.
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !in_ready_o)
    else $error("result produced while idle");

  // Table full is only ever reported for an insert.
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && status == ST_FULL) |-> dp_stat.is_insert)
    else $error("table full reported for a non-insert item");

  // A nonzero handle only comes with a hit.
  a_handle_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.matched_handle != '0) |-> out_data_o.status == ST_OK)
    else $error("nonzero handle without a hit");
`endif

endmodule

[dv/binary_trie_prefix_lookup_checker.sv]
// Checker for the binary trie prefix lookup block: watches both channels,
// predicts each result with its own trie copy and compares. Uses btpl_pkg.
module binary_trie_prefix_lookup_checker import btpl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_ready_i,
  input  in_t    in_data_i,
  input  logic   out_valid_i,
  input  logic   out_ready_i,
  input  out_t   out_data_i,
  output int     fail_count_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [NODE_W-1:0]      kid [NODE_COUNT][2];
  logic                   has_route [NODE_COUNT];
  logic [HANDLE_BITS-1:0] route_of [NODE_COUNT];
  logic [NODE_W-1:0]      spare_nodes [NODE_COUNT];
  int                     spare_count;
  out_t                   awaited_results[$];

  function automatic int bit_at(logic [31:0] a, int lvl);
    return int'(a[31 - lvl]);
  endfunction

  function automatic void wipe_node(int n);
    kid[n][0] = '0;
    kid[n][1] = '0;
    has_route[n] = 1'b0;
    route_of[n] = '0;
  endfunction

  function automatic void trie_clear();
    for (int i = 0; i < NODE_COUNT; i++) wipe_node(i);
    for (int i = 0; i < NODE_COUNT - 1; i++) spare_nodes[i] = NODE_W'(NODE_COUNT - 1 - i);
    spare_count = NODE_COUNT - 1;
  endfunction

  // Applies one command to the shadow trie and returns the expected result.
  function automatic out_t trie_apply(in_t it);
    out_t r;
    int len, cur, lvl, nxt, need, n, parent;
    int path [32];
    r = '0;
    len = (it.prefix_length > 32) ? 32 : int'(it.prefix_length);
    cur = 0;
    case (it.cmd)
      CMD_LOOKUP: begin
        r.status = has_route[0] ? ST_OK : ST_MISS;
        r.matched_handle = route_of[0];
        for (lvl = 0; lvl < 32; lvl++) begin
          nxt = kid[cur][bit_at(it.address, lvl)];
          if (nxt == 0) break;
          cur = nxt;
          if (has_route[cur]) begin
            r.status = ST_OK;
            r.matched_handle = route_of[cur];
          end
        end
        if (r.status != ST_OK) r.matched_handle = '0;
      end
      CMD_INSERT: begin
        lvl = 0;
        while (lvl < len && kid[cur][bit_at(it.address, lvl)] != 0) begin
          cur = kid[cur][bit_at(it.address, lvl)];
          lvl++;
        end
        need = len - lvl;
        if (need > spare_count) begin
          r.status = ST_FULL;
        end else begin
          while (lvl < len) begin
            spare_count--;
            n = spare_nodes[spare_count];
            wipe_node(n);
            kid[cur][bit_at(it.address, lvl)] = NODE_W'(n);
            cur = n;
            lvl++;
          end
          has_route[cur] = 1'b1;
          route_of[cur] = it.route_handle;
          r.status = ST_OK;
        end
      end
      CMD_DELETE: begin
        r.status = ST_OK;
        for (lvl = 0; lvl < len; lvl++) begin
          nxt = kid[cur][bit_at(it.address, lvl)];
          if (nxt == 0) begin
            r.status = ST_MISS;
            break;
          end
          path[lvl] = nxt;
          cur = nxt;
        end
        if (r.status == ST_OK && !has_route[cur]) r.status = ST_MISS;
        if (r.status == ST_OK) begin
          has_route[cur] = 1'b0;
          route_of[cur] = '0;
          for (int i = len - 1; i >= 0; i--) begin
            n = path[i];
            parent = (i == 0) ? 0 : path[i - 1];
            if (has_route[n] || kid[n][0] != 0 || kid[n][1] != 0) break;
            kid[parent][bit_at(it.address, i)] = '0;
            wipe_node(n);
            if (spare_count < NODE_COUNT) begin
              spare_nodes[spare_count] = NODE_W'(n);
              spare_count++;
            end
          end
        end
      end
      default: r.status = ST_MISS;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      trie_clear();
      awaited_results.delete();
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) awaited_results.push_back(trie_apply(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want.status !== out_data_i.status
              || want.matched_handle !== out_data_i.matched_handle) begin
            $display("%0t: mismatch, expected status %0d handle %h, actual status %0d handle %h",
                     $time, want.status, want.matched_handle,
                     out_data_i.status, out_data_i.matched_handle);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = awaited_results.size();
endmodule

[dv/binary_trie_prefix_lookup_tb.sv]
// Testbench top of the binary trie prefix lookup block: drives commands and
// stalls, gives the verdict. Depends on btpl_pkg and the checker module.
module binary_trie_prefix_lookup_tb;
  import btpl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending;

  // Idle rates in percent; the stimulus changes them phase by phase.
  int   send_idle = 29;
  int   recv_idle = 52;
  // Set while the receiver is held off for a long stretch.
  bit   recv_hold = 1'b0;

  // A small pool of prefixes so inserts, lookups and deletes hit each other.
  logic [31:0] known_addr [16];
  logic [5:0]  known_len [16];

  always #10 clk = ~clk;

  binary_trie_prefix_lookup dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  binary_trie_prefix_lookup_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The receiver decides its ready afresh every cycle, so stalls land on
  // every phase of the block's work.
  always @(posedge clk) begin
    out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
  end

  // Offers one item: optional idle cycles first, then valid stays high with a
  // steady payload until the block takes it. Valid is dropped only by idle
  // cycles, so back-to-back items keep it high.
  task automatic send_cmd(logic [1:0] c, logic [31:0] a, logic [5:0] l, logic [15:0] h);
    in_t it;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.cmd = c;
    it.address = a;
    it.prefix_length = l;
    it.route_handle = h;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Picks a random command, mostly well-formed ones on the shared prefix pool.
  task automatic send_random();
    int k;
    int pick;
    logic [31:0] a;
    k = $urandom_range(15);
    pick = $urandom_range(99);
    a = known_addr[k] ^ ($urandom_range(1) ? 32'($urandom) >> known_len[k] : 32'd0);
    if (pick < 35) send_cmd(CMD_LOOKUP, a, 6'($urandom), 16'($urandom));
    else if (pick < 65) send_cmd(CMD_INSERT, a, known_len[k], 16'($urandom));
    else if (pick < 88) send_cmd(CMD_DELETE, a, known_len[k], 16'($urandom));
    else if (pick < 93) send_cmd(CMD_BAD, $urandom, 6'($urandom), 16'($urandom));
    else send_cmd(2'($urandom_range(2)), $urandom, 6'($urandom), 16'($urandom));
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      known_addr[i] = $urandom;
      known_len[i] = 6'($urandom_range(32));
    end
    known_len[0] = 6'd0;
    known_len[1] = 6'd32;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: the default route, full-length host routes, overwrite,
    // saturating prefix length, ignored bits beyond the prefix, misses,
    // deletes of absent prefixes and of route-less path nodes, the unused code.
    send_cmd(CMD_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
    send_cmd(CMD_DELETE, 32'h0000_0000, 6'd0, 16'h0000);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 6'd0, 16'hFFFF);
    send_cmd(CMD_LOOKUP, 32'h1234_5678, 6'd63, 16'h0000);
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h0001);
    send_cmd(CMD_INSERT, 32'h0000_0000, 6'd63, 16'hA5A5);
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'hFFFF);
    send_cmd(CMD_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFE, 6'd0, 16'h0000);
    send_cmd(CMD_INSERT, 32'hC0A8_FFFF, 6'd16, 16'h1111);
    send_cmd(CMD_INSERT, 32'hC0A8_0000, 6'd16, 16'h2222);
    send_cmd(CMD_LOOKUP, 32'hC0A8_0101, 6'd0, 16'h0000);
    send_cmd(CMD_DELETE, 32'hC0A8_0000, 6'd8, 16'h0000);
    send_cmd(CMD_DELETE, 32'h0A00_0000, 6'd8, 16'h0000);
    send_cmd(CMD_DELETE, 32'hC0A8_1234, 6'd16, 16'h0000);
    send_cmd(CMD_LOOKUP, 32'hC0A8_0101, 6'd0, 16'h0000);
    send_cmd(CMD_DELETE, 32'hFFFF_FFFF, 6'd40, 16'h0000);
    send_cmd(CMD_DELETE, 32'h5555_5555, 6'd0, 16'h0000);
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0000);
    send_cmd(CMD_BAD, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    send_cmd(CMD_DELETE, 32'h0000_0000, 6'd32, 16'h0000);

    // Table-full case: distinct /32 routes use up all the nodes, then some
    // inserts are refused, then random lookups run against the full table.
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 40; i++) send_cmd(CMD_INSERT, {i[7:0], 24'h5A5A5A} ^ 32'($urandom),
                                        6'd32, 16'(i));
    for (int i = 0; i < 40; i++) send_cmd(CMD_LOOKUP, $urandom, 6'd0, 16'h0000);

    // Random part in three idle settings, with one long receiver hold-off.
    send_idle = 29;
    recv_idle = 52;
    for (int i = 0; i < 280; i++) send_random();
    send_idle = 52;
    recv_idle = 29;
    fork
      begin
        recv_hold = 1'b1;
        repeat (600) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 280; i++) send_random();
    join
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 280; i++) send_random();
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Worst case per item is a delete that frees a node on every level, plus stalls; this
  // leaves a wide margin over the whole run including the clearing pass.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/btpl_pkg.sv
hw/rtl/btpl_datapath.sv
hw/rtl/btpl_ctrl.sv
hw/rtl/binary_trie_prefix_lookup.sv
dv/binary_trie_prefix_lookup_checker.sv
dv/binary_trie_prefix_lookup_tb.sv
